// ===== sv/indirect_branch_target_profiler_unit_macros.svh =====
// assertion macros for the indirect branch target profiler
// needs clk and rst_n in the scope where they are used
`ifndef INDIRECT_BRANCH_TARGET_PROFILER_UNIT_MACROS_SVH
`define INDIRECT_BRANCH_TARGET_PROFILER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IBTP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibtp assertion failed");
// next-cycle implication
`define IBTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibtp assertion failed");
`else
`define IBTP_ASSERT_NOW(lbl, ante, cons)
`define IBTP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/ibtp_pkg.sv =====
// shared types, constants and helpers for the branch target profiler
// no dependencies
`default_nettype none
package ibtp_pkg;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int INS_W  = 16;
    localparam int THR_W  = 16;
    localparam logic [INS_W-1:0] INSERT_MAX = '1;

    // one target slot: address and its hit count
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  hits;
    } tgt_rec_t;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction
endpackage
`default_nettype wire

// ===== sv/ibtp_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module ibtp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/indirect_branch_target_profiler_unit.sv =====
// Indirect branch target profiler, top level.
// Input channel (in_valid/in_ready) carries one branch item: source and target
// address. Output channel (out_valid/out_ready) returns one result item per
// input item. cfg_we/cfg_wdata write the 16 bit hit threshold, no wait.
// One comparator is reused under a sequencer: each stored source, target and
// recent slot searched passes through a check state (ram read), then a
// compare state.
// The block takes one item at a time; in_ready is high only when idle.
// The result is held on the outputs until out_ready; a stalled receiver
// simply holds the block in that state. Reset clears the entry count and
// control state; the rams need no clearing pass since entries are
// initialised when allocated and only written slots are read back.
// Depends on ibtp_pkg, ibtp_ram and the assertion macro header.
`default_nettype none
`include "indirect_branch_target_profiler_unit_macros.svh"
module indirect_branch_target_profiler_unit #(
    parameter int ENTRIES      = 64,
    parameter int TARGETS      = 16,
    parameter int RECENT_SLOTS = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ibtp_pkg::THR_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ibtp_pkg::ADDR_W-1:0] source_address,
    input  wire logic [ibtp_pkg::ADDR_W-1:0] target_address,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [$clog2(ENTRIES)-1:0]       entry_index,
    output logic [$clog2(TARGETS)-1:0]       target_slot,
    output logic [ibtp_pkg::CNT_W-1:0]       target_hits,
    output logic [ibtp_pkg::CNT_W-1:0]       dynamic_count,
    output logic                             new_source,
    output logic                             new_target,
    output logic                             recent_match,
    output logic                             recent_recorded,
    output logic                             table_full
);
    localparam int EW  = $clog2(ENTRIES);
    localparam int CW  = EW + 1;
    localparam int TW  = $clog2(TARGETS);
    localparam int RW  = (RECENT_SLOTS > 1) ? $clog2(RECENT_SLOTS) : 1;
    localparam int FW  = $clog2(RECENT_SLOTS + 1);
    localparam int TAW = $clog2(ENTRIES * TARGETS);
    localparam int RAW = $clog2(ENTRIES * RECENT_SLOTS);
    localparam int IW0 = (EW > TW) ? EW : TW;
    localparam int IW  = ((IW0 > FW) ? IW0 : FW) + 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SRC_CHK = 4'd1;
    localparam logic [3:0] ST_SRC_CMP = 4'd2;
    localparam logic [3:0] ST_ENT_RD  = 4'd3;
    localparam logic [3:0] ST_ENT_LD  = 4'd4;
    localparam logic [3:0] ST_TGT_CHK = 4'd5;
    localparam logic [3:0] ST_TGT_CMP = 4'd6;
    localparam logic [3:0] ST_REC_CHK = 4'd7;
    localparam logic [3:0] ST_REC_CMP = 4'd8;
    localparam logic [3:0] ST_WB      = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    // per entry record
    typedef struct packed {
        logic [ibtp_pkg::CNT_W-1:0] dyn;
        logic [ibtp_pkg::INS_W-1:0] ins;
        logic [TW-1:0]              ptr;
        logic [FW-1:0]              fill;
        logic [ibtp_pkg::CNT_W-1:0] rhit;
    } ent_rec_t;

    logic [3:0]                  state_reg, state_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [ibtp_pkg::THR_W-1:0]  thr_reg;
    logic [EW-1:0]               e_reg, e_next;
    logic [ibtp_pkg::ADDR_W-1:0] src_reg, src_next;
    logic [ibtp_pkg::ADDR_W-1:0] tgt_reg, tgt_next;
    ent_rec_t                    rec_reg, rec_next;
    logic [TW-1:0]               slot_reg, slot_next;
    logic [ibtp_pkg::CNT_W-1:0]  hits_reg, hits_next;
    logic                        nsrc_reg, nsrc_next;
    logic                        ntgt_reg, ntgt_next;
    logic                        rmatch_reg, rmatch_next;
    logic                        rrec_reg, rrec_next;
    logic                        full_reg, full_next;

    // ram ports
    logic                        src_we;
    logic [EW-1:0]               src_waddr;
    logic [ibtp_pkg::ADDR_W-1:0] src_rdata;
    logic                        ent_we;
    ent_rec_t                    ent_rdata;
    logic                        tgt_we;
    logic [TAW-1:0]              tgt_waddr, tgt_raddr, tgt_base;
    ibtp_pkg::tgt_rec_t          tgt_wdata, tgt_rdata;
    logic                        rec_we;
    logic [RAW-1:0]              rec_waddr, rec_raddr, rec_base;
    logic [ibtp_pkg::ADDR_W-1:0] rec_rdata;

    // shared comparator
    logic [ibtp_pkg::ADDR_W-1:0] cmp_a, cmp_b;
    logic                        cmp_eq;
    logic [IW-1:0]               used_w;
    logic [IW-1:0]               idx_inc;

    assign tgt_base  = TAW'(e_reg) * TAW'(TARGETS);
    assign rec_base  = RAW'(e_reg) * RAW'(RECENT_SLOTS);
    assign tgt_raddr = tgt_base + TAW'(idx_reg[TW-1:0]);
    assign rec_raddr = rec_base + RAW'(idx_reg[RW-1:0]);
    assign idx_inc   = idx_reg + 1'b1;
    assign used_w    = (rec_reg.ins >= ibtp_pkg::INS_W'(TARGETS)) ? IW'(TARGETS)
                                                                   : IW'(rec_reg.ins);

    // comparator operand selection
    always_comb
    begin
        cmp_b = (state_reg == ST_SRC_CMP) ? src_reg : tgt_reg;
        case (state_reg)
            ST_SRC_CMP: cmp_a = src_rdata;
            ST_TGT_CMP: cmp_a = tgt_rdata.addr;
            ST_REC_CMP: cmp_a = (idx_reg < IW'(rec_reg.fill)) ? rec_rdata : '0;
            default:    cmp_a = '0;
        endcase
    end
    assign cmp_eq = (cmp_a == cmp_b);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        e_next      = e_reg;
        src_next    = src_reg;
        tgt_next    = tgt_reg;
        rec_next    = rec_reg;
        slot_next   = slot_reg;
        hits_next   = hits_reg;
        nsrc_next   = nsrc_reg;
        ntgt_next   = ntgt_reg;
        rmatch_next = rmatch_reg;
        rrec_next   = rrec_reg;
        full_next   = full_reg;
        src_we      = 1'b0;
        src_waddr   = cnt_reg[EW-1:0];
        ent_we      = 1'b0;
        tgt_we      = 1'b0;
        tgt_waddr   = tgt_raddr;
        tgt_wdata   = '{addr: tgt_reg, hits: hits_reg};
        rec_we      = 1'b0;
        rec_waddr   = rec_base + RAW'(rec_reg.fill);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    src_next    = source_address;
                    tgt_next    = target_address;
                    idx_next    = '0;
                    nsrc_next   = 1'b0;
                    ntgt_next   = 1'b0;
                    rmatch_next = 1'b0;
                    rrec_next   = 1'b0;
                    full_next   = 1'b0;
                    state_next  = ST_SRC_CHK;
                end
            end
            ST_SRC_CHK:
            begin
                if (idx_reg == IW'(cnt_reg))
                begin
                    if (cnt_reg == CW'(ENTRIES))
                    begin
                        full_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // allocate a fresh entry
                        src_we     = 1'b1;
                        e_next     = cnt_reg[EW-1:0];
                        cnt_next   = cnt_reg + 1'b1;
                        nsrc_next  = 1'b1;
                        rec_next   = '{dyn: ibtp_pkg::CNT_W'(1), ins: '0, ptr: '0,
                                       fill: '0, rhit: '0};
                        idx_next   = '0;
                        state_next = ST_TGT_CHK;
                    end
                end
                else
                begin
                    state_next = ST_SRC_CMP;
                end
            end
            ST_SRC_CMP:
            begin
                if (cmp_eq)
                begin
                    e_next     = idx_reg[EW-1:0];
                    state_next = ST_ENT_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SRC_CHK;
                end
            end
            ST_ENT_RD:
            begin
                state_next = ST_ENT_LD;
            end
            ST_ENT_LD:
            begin
                rec_next     = ent_rdata;
                rec_next.dyn = ibtp_pkg::sat_inc(ent_rdata.dyn);
                idx_next     = '0;
                state_next   = ST_TGT_CHK;
            end
            ST_TGT_CHK:
            begin
                if (idx_reg == used_w)
                begin
                    // miss: insert or replace at the wrap pointer
                    tgt_we     = 1'b1;
                    tgt_waddr  = tgt_base + TAW'(rec_reg.ptr);
                    tgt_wdata  = '{addr: tgt_reg, hits: ibtp_pkg::CNT_W'(1)};
                    slot_next  = rec_reg.ptr;
                    hits_next  = ibtp_pkg::CNT_W'(1);
                    ntgt_next  = 1'b1;
                    if (rec_reg.ins != ibtp_pkg::INSERT_MAX)
                    begin
                        rec_next.ins = rec_reg.ins + 1'b1;
                        rec_next.ptr = (rec_reg.ptr == TW'(TARGETS - 1)) ? '0
                                                                        : rec_reg.ptr + 1'b1;
                    end
                    idx_next   = '0;
                    state_next = ST_REC_CHK;
                end
                else
                begin
                    state_next = ST_TGT_CMP;
                end
            end
            ST_TGT_CMP:
            begin
                if (cmp_eq)
                begin
                    tgt_we     = 1'b1;
                    tgt_wdata  = '{addr: tgt_reg, hits: ibtp_pkg::sat_inc(tgt_rdata.hits)};
                    slot_next  = idx_reg[TW-1:0];
                    hits_next  = ibtp_pkg::sat_inc(tgt_rdata.hits);
                    idx_next   = '0;
                    state_next = ST_REC_CHK;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_TGT_CHK;
                end
            end
            ST_REC_CHK:
            begin
                if (idx_reg == IW'(RECENT_SLOTS))
                begin
                    if ((rec_reg.fill < FW'(RECENT_SLOTS)) &&
                        (hits_reg > ibtp_pkg::CNT_W'(thr_reg)))
                    begin
                        rec_we        = 1'b1;
                        rec_next.fill = rec_reg.fill + 1'b1;
                        rrec_next     = 1'b1;
                    end
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_REC_CMP;
                end
            end
            ST_REC_CMP:
            begin
                if (cmp_eq)
                begin
                    rec_next.rhit = ibtp_pkg::sat_inc(rec_reg.rhit);
                    rmatch_next   = 1'b1;
                    state_next    = ST_WB;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_REC_CHK;
                end
            end
            ST_WB:
            begin
                ent_we     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            thr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        e_reg      <= e_next;
        src_reg    <= src_next;
        tgt_reg    <= tgt_next;
        rec_reg    <= rec_next;
        slot_reg   <= slot_next;
        hits_reg   <= hits_next;
        nsrc_reg   <= nsrc_next;
        ntgt_reg   <= ntgt_next;
        rmatch_reg <= rmatch_next;
        rrec_reg   <= rrec_next;
        full_reg   <= full_next;
    end

    // storage
    ibtp_ram #(.WIDTH(ibtp_pkg::ADDR_W), .DEPTH(ENTRIES)) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (src_reg),
        .raddr (idx_reg[EW-1:0]),
        .rdata (src_rdata)
    );

    ibtp_ram #(.WIDTH($bits(ent_rec_t)), .DEPTH(ENTRIES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (e_reg),
        .wdata (rec_reg),
        .raddr (e_reg),
        .rdata (ent_rdata)
    );

    ibtp_ram #(.WIDTH($bits(ibtp_pkg::tgt_rec_t)), .DEPTH(ENTRIES * TARGETS)) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (tgt_wdata),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    ibtp_ram #(.WIDTH(ibtp_pkg::ADDR_W), .DEPTH(ENTRIES * RECENT_SLOTS)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (tgt_reg),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    // result item, all zero but the flag when the table is full
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = (state_reg == ST_OUT);
    assign table_full      = full_reg;
    assign entry_index     = full_reg ? '0 : e_reg;
    assign target_slot     = full_reg ? '0 : slot_reg;
    assign target_hits     = full_reg ? '0 : hits_reg;
    assign dynamic_count   = full_reg ? '0 : rec_reg.dyn;
    assign new_source      = !full_reg && nsrc_reg;
    assign new_target      = !full_reg && ntgt_reg;
    assign recent_match    = !full_reg && rmatch_reg;
    assign recent_recorded = !full_reg && rrec_reg;

    // checks
    `IBTP_ASSERT_NOW(a_ready_excl, in_ready, !out_valid)
    `IBTP_ASSERT_NOW(a_full_cnt, out_valid && table_full, cnt_reg == CW'(ENTRIES))
    `IBTP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CW'(ENTRIES))
    `IBTP_ASSERT_NEXT(a_out_done, out_valid && out_ready, in_ready)
endmodule
`default_nettype wire

// ===== dv/indirect_branch_target_profiler_unit_tb.sv =====
// testbench for the indirect branch target profiler: random and directed branch items
// checked against a cycle-free predictor in a scoreboard class; needs ibtp_pkg and the rtl
`timescale 1ns / 100ps

module indirect_branch_target_profiler_unit_tb;
    localparam int N_ENTRIES = 64;
    localparam int N_TARGETS = 16;
    localparam int N_RECENT  = 2;
    localparam int POOL_SIZE = 60;

    typedef struct {
        logic [5:0]                 entry_index;
        logic [3:0]                 target_slot;
        logic [ibtp_pkg::CNT_W-1:0] target_hits;
        logic [ibtp_pkg::CNT_W-1:0] dynamic_count;
        logic                       new_source;
        logic                       new_target;
        logic                       recent_match;
        logic                       recent_recorded;
        logic                       table_full;
    } profile_result_t;

    int error_count = 0;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // profile model and queue of predicted results
    class profile_scoreboard;
        logic [ibtp_pkg::THR_W-1:0]  threshold;
        int                          used_entries;
        logic [ibtp_pkg::ADDR_W-1:0] src_tab [N_ENTRIES];
        logic [ibtp_pkg::CNT_W-1:0]  exec_cnt [N_ENTRIES];
        logic [ibtp_pkg::INS_W-1:0]  insert_cnt [N_ENTRIES];
        logic [ibtp_pkg::ADDR_W-1:0] tgt_tab [N_ENTRIES][N_TARGETS];
        logic [ibtp_pkg::CNT_W-1:0]  tgt_hits [N_ENTRIES][N_TARGETS];
        logic [ibtp_pkg::ADDR_W-1:0] recent_tab [N_ENTRIES][N_RECENT];
        int                          recent_used [N_ENTRIES];
        logic [ibtp_pkg::CNT_W-1:0]  recent_hits [N_ENTRIES];
        profile_result_t             pending_results [$];

        function new();
            threshold = '0;
            used_entries = 0;
            for (int e = 0; e < N_ENTRIES; e++)
            begin
                exec_cnt[e] = '0;
                insert_cnt[e] = '0;
                recent_used[e] = 0;
                recent_hits[e] = '0;
                for (int r = 0; r < N_RECENT; r++)
                    recent_tab[e][r] = '0;
            end
        endfunction

        function logic [ibtp_pkg::CNT_W-1:0] bump(input logic [ibtp_pkg::CNT_W-1:0] v);
            return (v == '1) ? v : v + 1;
        endfunction

        // work out the result of one accepted branch item
        function void note_branch(input logic [ibtp_pkg::ADDR_W-1:0] src,
                                  input logic [ibtp_pkg::ADDR_W-1:0] tgt);
            profile_result_t res;
            int e;
            int i;
            int searched;
            int slot;
            res = '{default: '0};
            e = used_entries;
            for (i = 0; i < used_entries; i++)
            begin
                if (src_tab[i] == src)
                begin
                    e = i;
                    break;
                end
            end
            if (e == used_entries)
            begin
                if (used_entries >= N_ENTRIES)
                begin
                    res.table_full = 1'b1;
                    pending_results.push_back(res);
                    return;
                end
                used_entries++;
                src_tab[e] = src;
                insert_cnt[e] = '0;
                recent_hits[e] = '0;
                res.new_source = 1'b1;
            end
            exec_cnt[e] = bump(exec_cnt[e]);

            // target lookup, replacement round robin once full
            searched = (insert_cnt[e] > N_TARGETS) ? N_TARGETS : int'(insert_cnt[e]);
            slot = -1;
            for (i = 0; i < searched; i++)
            begin
                if (tgt_tab[e][i] == tgt)
                begin
                    slot = i;
                    break;
                end
            end
            if (slot >= 0)
                tgt_hits[e][slot] = bump(tgt_hits[e][slot]);
            else
            begin
                slot = int'(insert_cnt[e]) % N_TARGETS;
                tgt_tab[e][slot] = tgt;
                tgt_hits[e][slot] = 1;
                if (insert_cnt[e] != ibtp_pkg::INSERT_MAX)
                    insert_cnt[e] = insert_cnt[e] + 1;
                res.new_target = 1'b1;
            end

            // recent slots
            for (i = 0; i < N_RECENT; i++)
            begin
                if (recent_tab[e][i] == tgt)
                begin
                    recent_hits[e] = bump(recent_hits[e]);
                    res.recent_match = 1'b1;
                    break;
                end
            end
            if (!res.recent_match && recent_used[e] < N_RECENT &&
                tgt_hits[e][slot] > {16'b0, threshold})
            begin
                recent_tab[e][recent_used[e]] = tgt;
                recent_used[e]++;
                res.recent_recorded = 1'b1;
            end

            res.entry_index = e[5:0];
            res.target_slot = slot[3:0];
            res.target_hits = tgt_hits[e][slot];
            res.dynamic_count = exec_cnt[e];
            pending_results.push_back(res);
        endfunction

        // compare one observed result with the oldest prediction
        task check_result(input profile_result_t got);
            profile_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.entry_index !== want.entry_index)
                report_mismatch("entry_index", got.entry_index, want.entry_index);
            if (got.target_slot !== want.target_slot)
                report_mismatch("target_slot", got.target_slot, want.target_slot);
            if (got.target_hits !== want.target_hits)
                report_mismatch("target_hits", got.target_hits, want.target_hits);
            if (got.dynamic_count !== want.dynamic_count)
                report_mismatch("dynamic_count", got.dynamic_count, want.dynamic_count);
            if (got.new_source !== want.new_source)
                report_mismatch("new_source", got.new_source, want.new_source);
            if (got.new_target !== want.new_target)
                report_mismatch("new_target", got.new_target, want.new_target);
            if (got.recent_match !== want.recent_match)
                report_mismatch("recent_match", got.recent_match, want.recent_match);
            if (got.recent_recorded !== want.recent_recorded)
                report_mismatch("recent_recorded", got.recent_recorded,
                                want.recent_recorded);
            if (got.table_full !== want.table_full)
                report_mismatch("table_full", got.table_full, want.table_full);
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [ibtp_pkg::THR_W-1:0]  cfg_wdata = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [ibtp_pkg::ADDR_W-1:0] source_address = '0;
    logic [ibtp_pkg::ADDR_W-1:0] target_address = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [5:0]                  entry_index;
    logic [3:0]                  target_slot;
    logic [ibtp_pkg::CNT_W-1:0]  target_hits;
    logic [ibtp_pkg::CNT_W-1:0]  dynamic_count;
    logic                        new_source;
    logic                        new_target;
    logic                        recent_match;
    logic                        recent_recorded;
    logic                        table_full;

    profile_scoreboard sb = new();
    logic [ibtp_pkg::ADDR_W-1:0] source_pool [POOL_SIZE];
    logic [ibtp_pkg::ADDR_W-1:0] target_pool [24];
    bit                          sender_busy_gaps = 1'b1;

    indirect_branch_target_profiler_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .source_address (source_address),
        .target_address (target_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entry_index    (entry_index),
        .target_slot    (target_slot),
        .target_hits    (target_hits),
        .dynamic_count  (dynamic_count),
        .new_source     (new_source),
        .new_target     (new_target),
        .recent_match   (recent_match),
        .recent_recorded(recent_recorded),
        .table_full     (table_full)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // drive one branch item, entered and left at a falling edge
    task automatic send_branch(input logic [ibtp_pkg::ADDR_W-1:0] src,
                               input logic [ibtp_pkg::ADDR_W-1:0] tgt);
        int gap;
        source_address = src;
        target_address = tgt;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_branch(src, tgt);
        @(negedge clk);
        gap = sender_busy_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // wait for the block to drain, then write the threshold
    task automatic write_threshold(input logic [ibtp_pkg::THR_W-1:0] value);
        in_valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        sb.threshold = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // receiver stalls
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // result monitor
    initial
    begin
        profile_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.entry_index = entry_index;
                got.target_slot = target_slot;
                got.target_hits = target_hits;
                got.dynamic_count = dynamic_count;
                got.new_source = new_source;
                got.new_target = new_target;
                got.recent_match = recent_match;
                got.recent_recorded = recent_recorded;
                got.table_full = table_full;
                sb.check_result(got);
            end
        end
    end

    // stimulus
    initial
    begin
        int waited;
        for (int i = 0; i < POOL_SIZE; i++)
            source_pool[i] = $urandom();
        for (int i = 0; i < 24; i++)
            target_pool[i] = $urandom();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero target meets the empty recent slots, then recent slots fill up
        send_branch(32'h0, 32'h0);
        send_branch(32'h0, 32'h0);
        send_branch(32'h0, 32'hFFFF_FFFF);
        send_branch(32'h0, 32'h5);
        send_branch(32'h0, 32'h6);
        send_branch(32'h0, 32'hFFFF_FFFF);
        // overflow one target list so slots get replaced
        for (int i = 0; i < 18; i++)
            send_branch(32'hFFFF_FFFF, 32'h1000 + i);
        send_branch(32'hFFFF_FFFF, 32'h1000);

        // random traffic over a pool of sources, several thresholds
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_threshold(16'd3);
                1: write_threshold(16'hFFFF);
                2: write_threshold(16'd0);
                default: write_threshold(16'($urandom_range(1, 6)));
            endcase
            for (int n = 0; n < 140; n++)
            begin
                sender_busy_gaps = (n % 50) >= 15;
                if ($urandom_range(0, 19) == 0)
                    send_branch($urandom(), $urandom());
                else if ($urandom_range(0, 3) == 0)
                    send_branch(source_pool[$urandom_range(0, 7)],
                                target_pool[$urandom_range(0, 23)]);
                else
                    send_branch(source_pool[$urandom_range(0, POOL_SIZE - 1)],
                                target_pool[$urandom_range(0, 5)]);
            end
        end

        // fill the table and go past it
        sender_busy_gaps = 1'b1;
        write_threshold(16'($urandom()));
        for (int n = 0; n < 70; n++)
        begin
            send_branch($urandom(), $urandom());
            if (n % 7 == 0)
                send_branch(source_pool[$urandom_range(0, POOL_SIZE - 1)],
                            target_pool[$urandom_range(0, 23)]);
        end
        in_valid = 1'b0;

        // drain
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (200) @(negedge clk);
        if (error_count == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/ibtp_pkg.sv
sv/ibtp_ram.sv
sv/indirect_branch_target_profiler_unit.sv
dv/indirect_branch_target_profiler_unit_tb.sv
